FILE: src/imu_derived_quantity_unit_defines.svh
// Assertion macros shared by the IMU derived quantity unit.
// Every macro samples on clk_i and is muted while rst_ni is low.
`ifndef IMU_DERIVED_QUANTITY_UNIT_DEFINES_SVH
`define IMU_DERIVED_QUANTITY_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_CHK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("check failed");
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("check failed");
`else
`define ASSERT_CHK(lbl, prop)
`define ASSERT_NEXT(lbl, pre, post)
`endif
`endif

FILE: src/imu_dq_pkg.sv
// ----------------------------------------------------------------------------
// imu_dq_pkg
// Shared types, constants and the arctangent table of the IMU quantity unit.
// ----------------------------------------------------------------------------
package imu_dq_pkg;

  localparam int FRAC_BITS         = 16;
  localparam int CORDIC_ITERATIONS = 24;
  localparam int AXIS_W            = 32;
  localparam int OP_W              = 4;
  localparam int SQ_W              = 64;
  localparam int ROOT_W            = 32;
  localparam int REM_W             = 35;
  localparam int CX_W              = 60;
  localparam int CZ_W              = 34;
  localparam int PRE_SHIFT         = 24;
  localparam int RND_SHIFT         = 54 - FRAC_BITS;
  localparam int PROD_W            = 62;

  localparam logic signed [CZ_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CZ_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic [29:0]            DEG_PER_RAD_Q24 = 30'd961263669;
  localparam logic [ROOT_W-1:0]      OUT_MAX = 32'h7FFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_AX, OP_AY, OP_AZ, OP_GX, OP_GY, OP_GZ, OP_AMAG, OP_GMAG, OP_PITCH, OP_ROLL
  } op_e;

  typedef struct packed {
    logic                     vld;
    logic [OP_W-1:0]          op;
    logic [AXIS_W-1:0]        q;
    logic signed [AXIS_W:0]   y;
    logic signed [AXIS_W:0]   x;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [SQ_W-1:0]   n;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic yzero;
    logic xzero;
    logic xneg;
    logic yneg;
  } qflag_t;

  typedef struct packed {
    side_t                  side;
    qflag_t                 fl;
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [CZ_W-1:0] z;
  } cr_t;

  function automatic logic [31:0] atan_q30(logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h3243F6A8;  5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;  5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;  5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;  5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;  5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;  5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;  5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;  5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;  5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;  5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;  5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;  5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;  5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;  5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;  5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;  5'd31: v = 32'h00000000;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic logic [AXIS_W-1:0] abs32(logic signed [AXIS_W-1:0] v);
    return v[AXIS_W-1] ? AXIS_W'(-v) : AXIS_W'(v);
  endfunction

  function automatic logic [AXIS_W:0] abs33(logic signed [AXIS_W:0] v);
    return v[AXIS_W] ? (AXIS_W+1)'(-v) : (AXIS_W+1)'(v);
  endfunction

endpackage

FILE: src/imu_derived_quantity_unit.sv
// ----------------------------------------------------------------------------
// imu_derived_quantity_unit
// Raw axes, vector magnitudes and pitch/roll angles from one IMU sample.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one sample per word: tdata holds accel x/y/z and
//   gyro x/y/z (Q16.16), tuser holds the 4-bit selector. The master stream
//   returns one word per sample: tdata is the Q16.16 quantity, tuser[0] flags
//   a known selector. Results leave in input order.
//   Every word runs the full pipeline: square stage, sum stage, 32 square
//   root cells, operand stage, CORDIC_ITERATIONS rotation cells, angle stage,
//   degree multiply stage and the output register. Throughput is one word
//   per cycle while the master side does not stall; each cell hands its
//   word to the next whenever the chain advances.
//   A stall on the master side freezes the whole chain; the slave side keeps
//   taking words while the output register is empty or being drained.
//   Reset clears all valid flags; no word is in flight afterward.
// ----------------------------------------------------------------------------
`include "imu_derived_quantity_unit_defines.svh"
module imu_derived_quantity_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  input  logic [191:0] s_axis_tdata,
  // operation
  input  logic [imu_dq_pkg::OP_W-1:0] s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // quantity
  output logic [imu_dq_pkg::AXIS_W-1:0] m_axis_tdata,
  // known_code
  output logic [0:0]   m_axis_tuser
);
  import imu_dq_pkg::*;

  localparam int NSQ = ROOT_W;

  logic en;
  logic signed [AXIS_W-1:0] ax, ay, az, gx, gy, gz;
  logic [OP_W-1:0] op;

  assign ax = s_axis_tdata[31:0];
  assign ay = s_axis_tdata[63:32];
  assign az = s_axis_tdata[95:64];
  assign gx = s_axis_tdata[127:96];
  assign gy = s_axis_tdata[159:128];
  assign gz = s_axis_tdata[191:160];
  assign op = s_axis_tuser;

  // ---- square stage
  side_t            a_side_d, a_side_q;
  logic [AXIS_W-1:0] m0, m1, m2;
  logic [SQ_W-1:0]  s0_q, s1_q, s2_q;

  always_comb begin
    a_side_d     = '0;
    a_side_d.vld = s_axis_tvalid;
    a_side_d.op  = op;
    m0 = '0; m1 = '0; m2 = '0;
    unique case (op)
      OP_AX: a_side_d.q = ax;
      OP_AY: a_side_d.q = ay;
      OP_AZ: a_side_d.q = az;
      OP_GX: a_side_d.q = gx;
      OP_GY: a_side_d.q = gy;
      OP_GZ: a_side_d.q = gz;
      OP_AMAG: begin
        m0 = abs32(ax); m1 = abs32(ay); m2 = abs32(az);
      end
      OP_GMAG: begin
        m0 = abs32(gx); m1 = abs32(gy); m2 = abs32(gz);
      end
      OP_PITCH: begin
        m1 = abs32(ay); m2 = abs32(az);
        a_side_d.y = -$signed({ax[AXIS_W-1], ax});
      end
      OP_ROLL: begin
        a_side_d.y = $signed({ay[AXIS_W-1], ay});
        a_side_d.x = $signed({az[AXIS_W-1], az});
      end
      default: a_side_d.q = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_side_q.vld <= 1'b0;
    end else if (en) begin
      a_side_q <= a_side_d;
      s0_q     <= SQ_W'(m0) * SQ_W'(m0);
      s1_q     <= SQ_W'(m1) * SQ_W'(m1);
      s2_q     <= SQ_W'(m2) * SQ_W'(m2);
    end
  end

  // ---- sum stage, then the square root chain
  sq_t sq [NSQ+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq[0].side.vld <= 1'b0;
    end else if (en) begin
      sq[0].side <= a_side_q;
      sq[0].n    <= s0_q + s1_q + s2_q;
      sq[0].rem  <= '0;
      sq[0].root <= '0;
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    imu_dq_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .a_i    (sq[k]),
      .b_o    (sq[k+1])
    );
  end

  // ---- operand stage: magnitude result, quadrant folding
  cr_t                 cr [CORDIC_ITERATIONS+1];
  cr_t                 c_d;
  logic signed [AXIS_W:0] cxs, cys;
  logic [AXIS_W:0]     cxa, cya;
  logic [ROOT_W-1:0]   root;

  always_comb begin
    root     = sq[NSQ].root;
    c_d      = '0;
    c_d.side = sq[NSQ].side;
    if (sq[NSQ].side.op == OP_AMAG || sq[NSQ].side.op == OP_GMAG) begin
      c_d.side.q = (root > OUT_MAX) ? OUT_MAX : root;
    end
    cys = sq[NSQ].side.y;
    cxs = (sq[NSQ].side.op == OP_PITCH) ? $signed({1'b0, root}) : sq[NSQ].side.x;
    c_d.side.x = cxs;
    cxa = abs33(cxs);
    cya = abs33(cys);
    c_d.fl.yzero = (cys == '0);
    c_d.fl.xzero = (cxs == '0);
    c_d.fl.xneg  = cxs[AXIS_W];
    c_d.fl.yneg  = cys[AXIS_W];
    c_d.x = $signed({{(CX_W-AXIS_W-1-PRE_SHIFT){1'b0}}, cxa, {PRE_SHIFT{1'b0}}});
    c_d.y = $signed({{(CX_W-AXIS_W-1-PRE_SHIFT){1'b0}}, cya, {PRE_SHIFT{1'b0}}});
    c_d.z = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr[0].side.vld <= 1'b0;
    end else if (en) begin
      cr[0] <= c_d;
    end
  end

  for (genvar k = 0; k < CORDIC_ITERATIONS; k++) begin : g_cordic
    imu_dq_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .idx_i  (5'(k)),
      .a_i    (cr[k]),
      .b_o    (cr[k+1])
    );
  end

  // ---- angle stage
  cr_t                    cl;
  logic signed [CZ_W-1:0] zc, ang;
  logic                   neg_d;
  side_t                  d_side_q;
  logic [AXIS_W-1:0]      d_ang_q;
  logic                   d_neg_q;

  always_comb begin
    cl = cr[CORDIC_ITERATIONS];
    zc = cl.z;
    if (zc < 0) zc = '0;
    if (zc > HALF_PI_Q30) zc = HALF_PI_Q30;
    if (cl.fl.yzero) begin
      ang   = cl.fl.xneg ? PI_Q30 : '0;
      neg_d = 1'b0;
    end else if (cl.fl.xzero) begin
      ang   = HALF_PI_Q30;
      neg_d = cl.fl.yneg;
    end else begin
      ang   = cl.fl.xneg ? (PI_Q30 - zc) : zc;
      neg_d = cl.fl.yneg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_side_q.vld <= 1'b0;
    end else if (en) begin
      d_side_q <= cl.side;
      d_ang_q  <= ang[AXIS_W-1:0];
      d_neg_q  <= neg_d;
    end
  end

  // ---- degree multiply stage
  side_t             e_side_q;
  logic [PROD_W-1:0] e_prod_q;
  logic              e_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_side_q.vld <= 1'b0;
    end else if (en) begin
      e_side_q <= d_side_q;
      e_prod_q <= PROD_W'(d_ang_q) * PROD_W'(DEG_PER_RAD_Q24);
      e_neg_q  <= d_neg_q;
    end
  end

  // ---- output register: round, restore sign, select
  logic [PROD_W:0]   rnd;
  logic [AXIS_W-1:0] mag, deg, q_d;
  logic              known_d;
  logic              out_vld_q;
  logic [AXIS_W-1:0] out_q_q;
  logic              out_known_q;

  always_comb begin
    rnd     = (PROD_W+1)'(e_prod_q) + ((PROD_W+1)'(1) << (RND_SHIFT - 1));
    mag     = AXIS_W'(rnd >> RND_SHIFT);
    deg     = e_neg_q ? AXIS_W'(-mag) : mag;
    known_d = (e_side_q.op <= OP_ROLL);
    q_d     = (e_side_q.op == OP_PITCH || e_side_q.op == OP_ROLL) ? deg : e_side_q.q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q   <= e_side_q.vld;
      out_q_q     <= q_d;
      out_known_q <= known_d;
    end
  end

  // advance the whole chain unless a finished word is held
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q_q;
  assign m_axis_tuser  = out_known_q;

  `ASSERT_CHK(unknown_gives_zero_a, (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
  `ASSERT_CHK(angle_in_range_a, d_side_q.vld |-> ($signed({2'b00, d_ang_q}) <= PI_Q30))
  `ASSERT_NEXT(accept_fills_front_a, en && s_axis_tvalid, a_side_q.vld)
endmodule

FILE: src/imu_dq_sqrt_cell.sv
// ----------------------------------------------------------------------------
// imu_dq_sqrt_cell
// One digit of a restoring integer square root: two radicand bits per cell.
// ----------------------------------------------------------------------------
module imu_dq_sqrt_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  imu_dq_pkg::sq_t  a_i,
  output imu_dq_pkg::sq_t  b_o
);
  import imu_dq_pkg::*;

  sq_t              b_d, b_q;
  logic [REM_W-1:0] r, t;
  logic             ge;

  always_comb begin
    r  = {a_i.rem[REM_W-3:0], a_i.n[SQ_W-1 -: 2]};
    t  = REM_W'({a_i.root, 2'b01});
    ge = (r >= t);
    b_d      = a_i;
    b_d.n    = {a_i.n[SQ_W-3:0], 2'b00};
    b_d.rem  = ge ? (r - t) : r;
    b_d.root = {a_i.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q.side.vld <= 1'b0;
    end else if (en_i) begin
      b_q <= b_d;
    end
  end

  assign b_o = b_q;
endmodule

FILE: src/imu_dq_cordic_cell.sv
// ----------------------------------------------------------------------------
// imu_dq_cordic_cell
// One vectoring-mode CORDIC rotation; idx_i selects shift and table angle.
// ----------------------------------------------------------------------------
module imu_dq_cordic_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [4:0]       idx_i,
  input  imu_dq_pkg::cr_t  a_i,
  output imu_dq_pkg::cr_t  b_o
);
  import imu_dq_pkg::*;

  cr_t                    b_d, b_q;
  logic signed [CX_W-1:0] xs, ys;
  logic signed [CZ_W-1:0] at;

  always_comb begin
    xs  = a_i.x >>> idx_i;
    ys  = a_i.y >>> idx_i;
    at  = $signed({2'b00, atan_q30(idx_i)});
    b_d = a_i;
    if (!a_i.y[CX_W-1]) begin
      b_d.x = a_i.x + ys;
      b_d.y = a_i.y - xs;
      b_d.z = a_i.z + at;
    end else begin
      b_d.x = a_i.x - ys;
      b_d.y = a_i.y + xs;
      b_d.z = a_i.z - at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q.side.vld <= 1'b0;
    end else if (en_i) begin
      b_q <= b_d;
    end
  end

  assign b_o = b_q;
endmodule

FILE: test/tb_imu_derived_quantity_unit.sv
// ----------------------------------------------------------------------------
// tb_imu_derived_quantity_unit
// Stream-level test of the IMU quantity unit: directed corner samples, random
// samples over all selectors, output back-pressure and input gaps. Each output
// word is checked against a bit-exact software model of the datapath.
// ----------------------------------------------------------------------------
module tb_imu_derived_quantity_unit;
  import imu_dq_pkg::*;

  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  DRAIN_WAIT  = 200;
  localparam longint unsigned DEG_Q24 = 64'd961263669;
  localparam longint PI_RAD  = 64'sd3373259426;
  localparam longint HPI_RAD = 64'sd1686629713;

  typedef struct {
    logic [31:0] quantity;
    logic        known;
  } quantity_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic [OP_W-1:0] s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [AXIS_W-1:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  quantity_t    pending_q[$];
  int           mismatches = 0;
  int           words_sent = 0;
  int           words_checked = 0;
  int           cycles = 0;
  int           hold_off = 0;     // receiver stall, counted down in cycles
  bit           sink_idle_en = 1'b1;
  bit           src_idle_en = 1'b1;
  logic [31:0]  atan_tab [0:31] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000};

  imu_derived_quantity_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #2 clk_i = ~clk_i;

  // ---------------- model ----------------
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned square(longint v);
    longint unsigned a = v < 0 ? -v : v;
    return a * a;
  endfunction

  function automatic logic [31:0] vec_length(longint a, longint b, longint c);
    longint unsigned r = floor_sqrt(square(a) + square(b) + square(c));
    return r > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : r[31:0];
  endfunction

  // first-quadrant arctangent in Q2.30 radians
  function automatic longint vector_angle(longint x, longint y);
    longint z = 0;
    longint xs, ys;
    x = x <<< PRE_SHIFT;
    y = y <<< PRE_SHIFT;
    for (int i = 0; i < CORDIC_ITERATIONS && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(atan_tab[i]);
      end else begin
        x -= ys; y += xs; z -= longint'(atan_tab[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > HPI_RAD) z = HPI_RAD;
    return z;
  endfunction

  function automatic logic [31:0] angle_degrees(longint y, longint x);
    longint ang, z;
    longint unsigned deg;
    if (y == 0) ang = x < 0 ? PI_RAD : 0;
    else if (x == 0) ang = y < 0 ? -HPI_RAD : HPI_RAD;
    else begin
      z = vector_angle(x < 0 ? -x : x, y < 0 ? -y : y);
      if (x < 0) z = PI_RAD - z;
      ang = y < 0 ? -z : z;
    end
    deg = longint'(ang < 0 ? -ang : ang) * DEG_Q24;
    deg = (deg + (64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
    if (ang < 0) deg = 64'd0 - deg;
    return deg[31:0];
  endfunction

  function automatic quantity_t derive_quantity(logic [191:0] smp, logic [OP_W-1:0] op);
    quantity_t r;
    longint ax, ay, az, gx, gy, gz;
    ax = longint'($signed(smp[31:0]));    ay = longint'($signed(smp[63:32]));
    az = longint'($signed(smp[95:64]));   gx = longint'($signed(smp[127:96]));
    gy = longint'($signed(smp[159:128])); gz = longint'($signed(smp[191:160]));
    r.known = 1'b1;
    case (op)
      OP_AX:    r.quantity = smp[31:0];
      OP_AY:    r.quantity = smp[63:32];
      OP_AZ:    r.quantity = smp[95:64];
      OP_GX:    r.quantity = smp[127:96];
      OP_GY:    r.quantity = smp[159:128];
      OP_GZ:    r.quantity = smp[191:160];
      OP_AMAG:  r.quantity = vec_length(ax, ay, az);
      OP_GMAG:  r.quantity = vec_length(gx, gy, gz);
      OP_PITCH: r.quantity = angle_degrees(-ax, longint'(floor_sqrt(square(ay) + square(az))));
      OP_ROLL:  r.quantity = angle_degrees(ay, az);
      default: begin
        r.quantity = '0;
        r.known = 1'b0;
      end
    endcase
    return r;
  endfunction

  // ---------------- drivers ----------------
  function automatic int idle_len();
    int p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_sample(logic [31:0] ax, ay, az, gx, gy, gz, logic [OP_W-1:0] op);
    int gap = src_idle_en ? idle_len() : 0;
    if (gap > 0) begin
      // drop valid for the idle stretch
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {gz, gy, gx, az, ay, ax};
    s_axis_tuser  <= op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_q.push_back(derive_quantity({gz, gy, gx, az, ay, ax}, op));
    words_sent++;
    @(negedge clk_i);
  endtask

  // receiver: random stalls plus forced hold-off
  initial begin
    int run;
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        m_axis_tready <= 1'b0;
        hold_off--;
      end else if (sink_idle_en && $urandom_range(3) == 0) begin
        m_axis_tready <= 1'b0;
        run = idle_len();
        repeat (run) begin
          @(negedge clk_i);
        end
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------- checker ----------------
  always @(posedge clk_i) begin
    quantity_t e;
    cycles <= cycles + 1;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word q=%h known=%b", $time, m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        e = pending_q.pop_front();
        words_checked++;
        if (m_axis_tdata !== e.quantity) begin
          $display("%0t: quantity exp %h got %h", $time, e.quantity, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser[0] !== e.known) begin
          $display("%0t: known exp %b got %b", $time, e.known, m_axis_tuser[0]);
          mismatches++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d words outstanding", pending_q.size());
      $display("tb_imu_derived_quantity_unit: FAIL");
      $finish;
    end
  end

  // ---------------- tests ----------------
  function automatic logic [31:0] rand_axis();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom();
      2: return 32'($signed($urandom_range(2000000)) - 1000000);
      3: return 32'($signed($urandom_range(64)) - 32);
      4: return 32'h0;
      default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_corners();
    logic [31:0] mx = 32'h7FFF_FFFF, mn = 32'h8000_0000;
    for (int op = 0; op < 16; op++)
      send_sample(mn, mx, mn, mx, mn, mx, OP_W'(op));
    send_sample(mn, mn, mn, mn, mn, mn, OP_AMAG);         // saturate
    send_sample(0, 0, 0, 0, 0, 0, OP_ROLL);               // atan2 of origin
    send_sample(0, 0, 0, 0, 0, 0, OP_PITCH);
    send_sample(5, 0, -32'sd65536, 0, 0, 0, OP_ROLL);     // half turn
    send_sample(0, 32'sd65536, 0, 0, 0, 0, OP_ROLL);      // plus quarter
    send_sample(0, -32'sd65536, 0, 0, 0, 0, OP_ROLL);     // minus quarter
    send_sample(mn, 0, 0, 0, 0, 0, OP_PITCH);
    send_sample(mx, 3, 4, 0, 0, 0, OP_PITCH);
  endtask

  task automatic test_random(int n);
    logic [31:0] a[6];
    logic [OP_W-1:0] op;
    for (int k = 0; k < n; k++) begin
      foreach (a[j]) a[j] = rand_axis();
      op = ($urandom_range(9) == 0) ? OP_W'($urandom_range(15, 10))
                                    : OP_W'($urandom_range(9));
      send_sample(a[0], a[1], a[2], a[3], a[4], a[5], op);
      // stretches without any idling
      if (k % 400 == 200) begin src_idle_en = 1'b0; sink_idle_en = 1'b0; end
      if (k % 400 == 300) begin src_idle_en = 1'b1; sink_idle_en = 1'b1; end
    end
  endtask

  task automatic test_backpressure();
    src_idle_en = 1'b0;
    hold_off = 400;
    for (int k = 0; k < 150; k++)
      send_sample($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom(), OP_W'($urandom_range(15)));
    src_idle_en = 1'b1;
  endtask

  task automatic test_pause_drain();
    test_random(20);
    wait_drained();
    test_random(20);
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    test_corners();
    test_backpressure();
    test_pause_drain();
    test_random(1800);
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk_i);
    $display("sent %0d samples over all selectors, checked %0d words, %0d mismatches",
             words_sent, words_checked, mismatches);
    $display("covered corners, saturation, zero vectors, long stalls and drained pauses");
    if (mismatches == 0 && pending_q.size() == 0)
      $display("tb_imu_derived_quantity_unit: PASS");
    else
      $display("tb_imu_derived_quantity_unit: FAIL");
    $finish;
  end

endmodule
